@@ rtl/lzd_pkg.sv @@
// shared constants, helper functions and control structs for the lzss decoder
// depends on nothing; the top level, lzd_bitbuf and the testbench import it
package lzd_pkg;

  localparam int WIN_BITS_DEFAULT    = 8;
  localparam int LENGTH_BITS_DEFAULT = 4;
  localparam int BYTE_BITS           = 8;
  localparam int OUT_LEN_BITS        = 32;
  localparam int LIT_TOKEN_BITS      = 1 + BYTE_BITS;

  // flag bit, window position and count field
  function automatic int match_token_bits(input int wbits, input int lbits);
    return 1 + wbits + lbits;
  endfunction

  // shortest copy: a match token must never expand the data
  function automatic int match_min(input int wbits, input int lbits);
    return (match_token_bits(wbits, lbits) + 7) >> 3;
  endfunction

  function automatic int max_results(input int wbits, input int lbits);
    return (1 << lbits) + match_min(wbits, lbits) - 1;
  endfunction

  // first write position, taken modulo the window size
  function automatic int window_start(input int wbits, input int lbits);
    return ((2 << wbits) - max_results(wbits, lbits)) & ((1 << wbits) - 1);
  endfunction

  typedef struct packed {
    logic clear;
    logic append;
    logic take_lit;
    logic take_match;
  } bb_cmd_t;

  typedef struct packed {
    logic token_ready;
    logic flag;
  } bb_stat_t;

endpackage

@@ rtl/lzd_if.sv @@
// valid/ready channel interfaces for compressed input and decompressed output
// depends on nothing
interface lzd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_of_stream;

  modport source (output valid, in_byte, start_of_stream, input ready);
  modport sink (input valid, in_byte, start_of_stream, output ready);
endinterface

interface lzd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       stream_done;

  modport source (output valid, out_byte, last_of_run, stream_done, input ready);
  modport sink (input valid, out_byte, last_of_run, stream_done, output ready);
endinterface

@@ rtl/lzss_decoder_8bit_window_top.sv @@
// lzss decoder top level: sequencer, window ram and output register
// depends on lzd_pkg, lzd_if, lzd_ram and lzd_bitbuf
//
// usage:
// - code carries compressed bytes, msb first; a word with start_of_stream set
//   clears the window, pointers and counts before its byte is decoded
// - data carries one decompressed byte per word; last_of_run marks the final
//   byte caused by one input word, stream_done the byte that reaches
//   out_length
// - cfg_we/cfg_wdata set out_length; write it while the block is idle
// - code.ready is high only while the sequencer waits for a byte; a literal
//   passes through a single emit step, while each byte copied by a match
//   needs one window ram read and one emit step
// - a start marker adds a window clearing sweep over all 2^WIN_BITS entries
//   (256 by default), one ram entry a cycle
// - after reset the same sweep runs before code.ready first rises
// - once out_length bytes are produced, input words are swallowed with no
//   output until the next start marker or a larger out_length
// - the output is a single register; a stalled receiver holds the sequencer
//   in its emit step, no byte is dropped
module lzss_decoder_8bit_window_top
  import lzd_pkg::*;
#(
  parameter int WIN_BITS    = WIN_BITS_DEFAULT,
  parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  lzd_in_if.sink                  code,
  lzd_out_if.source               data,
  input  logic                    cfg_we,
  input  logic [OUT_LEN_BITS-1:0] cfg_wdata
);

  localparam int WIN_SIZE = 1 << WIN_BITS;
  localparam int MIN_RUN  = match_min(WIN_BITS, LENGTH_BITS);
  localparam int MAX_RUN  = max_results(WIN_BITS, LENGTH_BITS);
  localparam int RUN_BITS = $clog2(MAX_RUN + 1);
  localparam logic [WIN_BITS-1:0] WIN_START =
    WIN_BITS'(window_start(WIN_BITS, LENGTH_BITS));

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0]              state, state_next;
  logic [OUT_LEN_BITS-1:0] out_length;
  logic [OUT_LEN_BITS-1:0] produced;
  logic [WIN_BITS-1:0]     wp;
  logic [WIN_BITS-1:0]     clr_addr;
  logic                    pend;
  logic                    is_lit;
  logic [RUN_BITS-1:0]     rem;
  logic                    out_valid;

  logic [BYTE_BITS-1:0]    held_byte;
  logic [BYTE_BITS-1:0]    lit_byte;
  logic [WIN_BITS-1:0]     rd_pos;
  logic [BYTE_BITS-1:0]    out_byte;
  logic                    out_last;
  logic                    out_done;

  bb_cmd_t                 bb_cmd;
  bb_stat_t                bb_stat;
  logic [BYTE_BITS-1:0]    bb_byte;
  logic [BYTE_BITS-1:0]    bb_lit;
  logic [WIN_BITS-1:0]     bb_pos;
  logic [LENGTH_BITS-1:0]  bb_len;

  logic                    ram_we, ram_re;
  logic [WIN_BITS-1:0]     ram_waddr;
  logic [BYTE_BITS-1:0]    ram_wdata, ram_rdata;

  logic                    accept, out_free, below, reach, emit_last, load_out;
  logic [BYTE_BITS-1:0]    emit_byte;

  assign accept    = code.valid && code.ready;
  assign out_free  = !out_valid || data.ready;
  assign below     = produced < out_length;
  assign reach     = (produced + OUT_LEN_BITS'(1)) == out_length;
  assign emit_byte = is_lit ? lit_byte : ram_rdata;
  // last byte of this input word: length reached or no further full token
  assign emit_last = reach || ((rem == RUN_BITS'(1)) && !bb_stat.token_ready);

  assign code.ready       = (state == S_IDLE);
  assign data.valid       = out_valid;
  assign data.out_byte    = out_byte;
  assign data.last_of_run = out_last;
  assign data.stream_done = out_done;

  assign bb_byte = (state == S_CLEAR) ? held_byte : code.in_byte;

  lzd_bitbuf #(
    .WIN_BITS    (WIN_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_bitbuf (
    .clk     (clk),
    .rst     (rst),
    .cmd     (bb_cmd),
    .byte_in (bb_byte),
    .stat    (bb_stat),
    .lit     (bb_lit),
    .pos     (bb_pos),
    .len     (bb_len)
  );

  lzd_ram #(
    .WIDTH (BYTE_BITS),
    .DEPTH (WIN_SIZE)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_pos),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    bb_cmd     = '0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = wp;
    ram_wdata  = emit_byte;
    load_out   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
        if (clr_addr == {WIN_BITS{1'b1}}) begin
          // produced is zero here, so any nonzero length lets the byte in
          if (pend && (out_length != '0)) begin
            bb_cmd.append = 1'b1;
            state_next    = S_DECODE;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (code.start_of_stream) begin
            bb_cmd.clear = 1'b1;
            state_next   = S_CLEAR;
          end else if (below) begin
            bb_cmd.append = 1'b1;
            state_next    = S_DECODE;
          end
        end
      end
      S_DECODE: begin
        if (below && bb_stat.token_ready) begin
          if (bb_stat.flag) begin
            bb_cmd.take_lit = 1'b1;
            state_next      = S_EMIT;
          end else begin
            bb_cmd.take_match = 1'b1;
            state_next        = S_READ;
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        ram_re     = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          ram_we   = 1'b1;
          if ((rem == RUN_BITS'(1)) || reach) begin
            state_next = S_DECODE;
          end else begin
            state_next = S_READ;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      out_length <= '0;
      produced   <= '0;
      wp         <= WIN_START;
      clr_addr   <= '0;
      pend       <= 1'b0;
      is_lit     <= 1'b0;
      rem        <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        out_length <= cfg_wdata;
      end
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + WIN_BITS'(1);
        if (clr_addr == {WIN_BITS{1'b1}}) begin
          pend <= 1'b0;
        end
      end
      if (accept && code.start_of_stream) begin
        produced <= '0;
        wp       <= WIN_START;
        clr_addr <= '0;
        pend     <= 1'b1;
      end
      if (bb_cmd.take_lit) begin
        is_lit <= 1'b1;
        rem    <= RUN_BITS'(1);
      end else if (bb_cmd.take_match) begin
        is_lit <= 1'b0;
        rem    <= RUN_BITS'(bb_len) + RUN_BITS'(MIN_RUN);
      end
      if (load_out) begin
        wp        <= wp + WIN_BITS'(1);
        produced  <= produced + OUT_LEN_BITS'(1);
        rem       <= rem - RUN_BITS'(1);
        out_valid <= 1'b1;
      end else if (data.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      held_byte <= code.in_byte;
    end
    if (bb_cmd.take_lit) begin
      lit_byte <= bb_lit;
    end
    if (bb_cmd.take_match) begin
      rd_pos <= bb_pos;
    end else if (load_out) begin
      rd_pos <= rd_pos + WIN_BITS'(1);
    end
    if (load_out) begin
      out_byte <= emit_byte;
      out_last <= emit_last;
      out_done <= reach;
    end
  end

endmodule

@@ rtl/lzd_ram.sv @@
// generic single write, single read ram with registered read data
// depends on nothing
module lzd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/lzd_bitbuf.sv @@
// bit accumulator: appends compressed bytes, checks for a complete token and
// strips tokens msb first through separate flag, literal and match shifters; uses lzd_pkg
module lzd_bitbuf
  import lzd_pkg::*;
#(
  parameter int WIN_BITS    = WIN_BITS_DEFAULT,
  parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  bb_cmd_t                cmd,
  input  logic [BYTE_BITS-1:0]   byte_in,
  output bb_stat_t               stat,
  output logic [BYTE_BITS-1:0]   lit,
  output logic [WIN_BITS-1:0]    pos,
  output logic [LENGTH_BITS-1:0] len
);

  localparam int MATCH_BITS = match_token_bits(WIN_BITS, LENGTH_BITS);
  localparam int ACC_BITS   = MATCH_BITS + 7;
  localparam int CNT_BITS   = $clog2(ACC_BITS + 1);

  localparam logic [CNT_BITS-1:0] LIT_N   = CNT_BITS'(LIT_TOKEN_BITS);
  localparam logic [CNT_BITS-1:0] MATCH_N = CNT_BITS'(MATCH_BITS);
  localparam logic [CNT_BITS-1:0] BYTE_N  = CNT_BITS'(BYTE_BITS);
  localparam logic [CNT_BITS-1:0] ONE_N   = CNT_BITS'(1);

  logic [ACC_BITS-1:0] acc, acc_next;
  logic [CNT_BITS-1:0] count, count_next;
  logic [ACC_BITS-1:0] flag_word, lit_word, match_word;
  logic [CNT_BITS-1:0] take_n, rest;

  // oldest pending bit sits at position count-1
  assign flag_word  = acc >> (count - ONE_N);
  assign lit_word   = acc >> (count - LIT_N);
  assign match_word = acc >> (count - MATCH_N);

  assign stat.flag        = flag_word[0];
  assign stat.token_ready = (count >= ONE_N) &&
                            (count >= (flag_word[0] ? LIT_N : MATCH_N));

  assign lit = lit_word[BYTE_BITS-1:0];
  assign pos = match_word[LENGTH_BITS +: WIN_BITS];
  assign len = match_word[LENGTH_BITS-1:0];

  assign take_n = cmd.take_lit ? LIT_N : MATCH_N;
  assign rest   = count - take_n;

  always_comb begin
    acc_next   = acc;
    count_next = count;
    if (cmd.clear) begin
      acc_next   = '0;
      count_next = '0;
    end else if (cmd.append) begin
      acc_next   = (acc << BYTE_BITS) | ACC_BITS'(byte_in);
      count_next = count + BYTE_N;
    end else if (cmd.take_lit || cmd.take_match) begin
      acc_next   = acc & ~({ACC_BITS{1'b1}} << rest);
      count_next = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      count <= '0;
    end else begin
      acc   <= acc_next;
      count <= count_next;
    end
  end

endmodule

@@ sim/tb_top.sv @@
// self-checking testbench for lzss_decoder_8bit_window_top: builds token streams,
// predicts every decompressed word and checks it on the data channel
// depends on lzd_pkg, lzd_if and the decoder top level from the rtl
module tb_top;
  import lzd_pkg::*;

  localparam int HIST_SIZE   = 256;
  localparam int HIST_START  = 239;
  localparam int MATCH_BITS  = 13;
  localparam int MATCH_MIN   = 2;
  localparam int MAX_OUT     = 17;
  localparam int SETTLE      = 320;
  localparam int CYCLE_LIMIT = 800000;
  localparam int RANDOM_WORDS = 70;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       stream_done;
  } out_word_t;

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic [OUT_LEN_BITS-1:0] cfg_wdata;

  lzd_in_if  code_if ();
  lzd_out_if data_if ();

  lzss_decoder_8bit_window_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .code      (code_if),
    .data      (data_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // decoder state as predicted
  logic [7:0]  hist [HIST_SIZE];
  logic [7:0]  hist_wp;
  logic [23:0] acc_reg;
  int          acc_bits;
  logic [31:0] produced;
  logic [31:0] len_limit;

  out_word_t   pending_bytes[$];
  logic        bit_fifo[$];
  int          fail_count;
  int          fed_words;
  int          rx_hold;
  bit          tx_idle_en;
  bit          rx_idle_en;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] take_bits(input int n);
    logic [23:0] v;
    acc_bits = acc_bits - n;
    v = (acc_reg >> acc_bits) & ((24'd1 << n) - 24'd1);
    acc_reg = acc_reg & ((24'd1 << acc_bits) - 24'd1);
    return v[7:0];
  endfunction

  // predicts the words caused by one accepted code word
  function automatic void decode_word(input logic [7:0] b, input logic sos);
    out_word_t  outs [MAX_OUT];
    int         n;
    int         need;
    int         cnt;
    logic       flag;
    logic [7:0] lit;
    logic [7:0] pos;
    logic [7:0] v;
    n = 0;
    fed_words++;
    if (sos) begin
      for (int i = 0; i < HIST_SIZE; i++) hist[i] = 8'd0;
      hist_wp  = 8'(HIST_START);
      acc_reg  = 24'd0;
      acc_bits = 0;
      produced = 32'd0;
    end
    if (produced >= len_limit) return;
    acc_reg  = {acc_reg[15:0], b};
    acc_bits = acc_bits + 8;
    while (produced < len_limit && acc_bits >= 1) begin
      flag = acc_reg[acc_bits-1];
      need = flag ? LIT_TOKEN_BITS : MATCH_BITS;
      if (acc_bits < need) break;
      void'(take_bits(1));
      pos  = 8'd0;
      lit  = 8'd0;
      if (flag) begin
        lit = take_bits(8);
        cnt = 1;
      end else begin
        pos = take_bits(8);
        cnt = take_bits(4) + MATCH_MIN;
      end
      for (int i = 0; i < cnt && produced < len_limit; i++) begin
        v = flag ? lit : hist[pos + i[7:0]];
        hist[hist_wp] = v;
        hist_wp  = hist_wp + 8'd1;
        produced = produced + 32'd1;
        outs[n].out_byte    = v;
        outs[n].last_of_run = 1'b0;
        outs[n].stream_done = 1'b0;
        n++;
      end
    end
    if (n > 0) begin
      outs[n-1].last_of_run = 1'b1;
      outs[n-1].stream_done = (produced == len_limit);
    end
    for (int i = 0; i < n; i++) pending_bytes = {pending_bytes, outs[i]};
  endfunction

  // msb of the value goes out first
  function automatic void put_bits(input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) bit_fifo = {bit_fifo, v[i]};
  endfunction

  function automatic void put_literal(input logic [7:0] b);
    put_bits(32'({1'b1, b}), LIT_TOKEN_BITS);
  endfunction

  function automatic void put_match(input logic [7:0] pos, input logic [3:0] cnt);
    put_bits(32'({1'b0, pos, cnt}), MATCH_BITS);
  endfunction

  task automatic send_word(input logic [7:0] b, input logic sos);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      code_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    code_if.valid           <= 1'b1;
    code_if.in_byte         <= b;
    code_if.start_of_stream <= sos;
    do @(posedge clk); while (code_if.ready !== 1'b1);
    decode_word(b, sos);
  endtask

  // packs the queued bits into words, random padding on the tail
  task automatic flush_bits(input logic first_sos);
    logic [7:0] b;
    logic       s;
    s = first_sos;
    while (bit_fifo.size() > 0) begin
      for (int i = 7; i >= 0; i--)
        b[i] = (bit_fifo.size() > 0) ? bit_fifo.pop_front() : 1'($urandom_range(0, 1));
      send_word(b, s);
      s = 1'b0;
    end
  endtask

  task automatic drain();
    code_if.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
  endtask

  // words that make no output may still be in flight, clear sweep included
  task automatic set_length(input logic [31:0] v);
    drain();
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    len_limit = v;
  endtask

  task automatic test_reset_length();
    // length is zero out of reset, so this word is swallowed
    send_word(8'hFF, 1'b0);
  endtask

  task automatic test_tokens();
    set_length(32'd1000);
    put_literal(8'h00);
    put_literal(8'hFF);
    put_literal(8'h5A);
    put_match(8'd239, 4'd0);
    put_match(8'd239, 4'd15);   // overlaps the bytes being written
    put_match(8'd0, 4'd15);
    put_match(8'd255, 4'd15);   // read wraps around the window
    put_match(8'd250, 4'd7);
    flush_bits(1'b1);
  endtask

  task automatic test_length_edges();
    set_length(32'd0);
    send_word(8'h80, 1'b1);
    // match cut short at the length, then a swallowed word
    set_length(32'd4);
    put_match(8'd0, 4'd15);
    flush_bits(1'b1);
    send_word(8'hC3, 1'b0);
    // length raised mid-stream: leftover bits decode again
    set_length(32'd6);
    put_literal(8'h3C);
    put_literal(8'hA5);
    flush_bits(1'b0);
    // length lowered below what was produced
    set_length(32'd3);
    send_word(8'h81, 1'b0);
    set_length(32'hFFFF_FFFF);
    put_literal(8'h7E);
    put_match(8'd239, 4'd3);
    flush_bits(1'b1);
  endtask

  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    set_length(32'd100000);
    rx_hold = 300;
    put_literal(8'h11);
    for (int i = 0; i < 12; i++) put_match(8'($urandom), 4'd15);
    flush_bits(1'b1);
    // sender waits for the whole backlog before going on
    drain();
    for (int i = 0; i < 6; i++) begin
      put_literal(8'($urandom));
      put_match(8'($urandom), 4'($urandom));
    end
    flush_bits(1'b0);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic random_stream();
    int          tokens;
    logic        sos;
    logic [31:0] len;
    sos = ($urandom_range(0, 4) != 0);
    case ($urandom_range(0, 9))
      0:       len = 32'hFFFF_FFFF;
      1:       len = $urandom_range(0, 3);
      default: len = $urandom_range(4, 60);
    endcase
    tx_idle_en = ($urandom_range(0, 3) != 0);
    rx_idle_en = ($urandom_range(0, 3) != 0);
    set_length(len);
    tokens = $urandom_range(2, 12);
    if ($urandom_range(0, 9) == 0) begin
      for (int i = 0; i < tokens; i++) put_bits($urandom, 8);
    end else begin
      for (int i = 0; i < tokens; i++) begin
        if ($urandom_range(0, 1)) put_literal(8'($urandom));
        else put_match(8'($urandom), 4'($urandom));
        // broken token boundary now and then
        if ($urandom_range(0, 14) == 0) put_bits($urandom, $urandom_range(1, 7));
      end
    end
    flush_bits(sos);
  endtask

  task automatic test_random();
    int goal;
    goal = fed_words + RANDOM_WORDS;
    while (fed_words < goal) random_stream();
  endtask

  // output side: random stalls, long hold on request, compare against prediction
  initial begin : rx_proc
    int        stall;
    out_word_t want;
    forever begin
      if (rx_hold > 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end else begin
        stall = rx_idle_en ? $urandom_range(0, 7) : 0;
      end
      if (stall > 0) begin
        data_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      data_if.ready <= 1'b1;
      do @(posedge clk); while (data_if.valid !== 1'b1);
      if (pending_bytes.size() == 0) begin
        $error("out_byte expected none actual %02h", data_if.out_byte);
        fail_count++;
      end else begin
        want = pending_bytes.pop_front();
        if (data_if.out_byte !== want.out_byte) begin
          $error("out_byte expected %02h actual %02h", want.out_byte, data_if.out_byte);
          fail_count++;
        end
        if (data_if.last_of_run !== want.last_of_run) begin
          $error("last_of_run expected %0b actual %0b", want.last_of_run,
                 data_if.last_of_run);
          fail_count++;
        end
        if (data_if.stream_done !== want.stream_done) begin
          $error("stream_done expected %0b actual %0b", want.stream_done,
                 data_if.stream_done);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : main_seq
    fail_count = 0;
    fed_words  = 0;
    rx_hold    = 0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    len_limit  = 32'd0;
    produced   = 32'd0;
    hist_wp    = 8'(HIST_START);
    acc_reg    = 24'd0;
    acc_bits   = 0;
    for (int i = 0; i < HIST_SIZE; i++) hist[i] = 8'd0;
    rst                     <= 1'b1;
    cfg_we                  <= 1'b0;
    cfg_wdata               <= '0;
    code_if.valid           <= 1'b0;
    code_if.in_byte         <= 8'd0;
    code_if.start_of_stream <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_length();
    test_tokens();
    test_length_edges();
    test_backpressure();
    test_random();
    drain();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

@@ files.f @@
rtl/lzd_pkg.sv
rtl/lzd_if.sv
rtl/lzd_ram.sv
rtl/lzd_bitbuf.sv
rtl/lzss_decoder_8bit_window_top.sv
sim/tb_top.sv
